// ===== hdl/ordered_array_insert_remove_unit_macros.svh =====
// Assertion macros used by the checker file of the ordered list unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_UNIT_MACROS_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define OAI_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define OAI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/oai_pkg.sv =====
// Shared types, constants and codes of the ordered list unit.
// Used by oai_cell, the top level and the checker; depends on nothing.
package oai_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int ELEM_W     = 32;
    localparam int INDEX_W    = 5;
    localparam int POSITION_W = 4;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = $clog2(CAPACITY);
    localparam int CMP_W      = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [POS_W-1:0]         cpos_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic [POSITION_W-1:0]    position_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_PRINT   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_EMPTY_REMOVE = 2'd2,
        ST_EMPTY_PRINT  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PRINT = 1'b1
    } state_t;

    // What every cell of the chain does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        cpos_t     pos;
        elem_t     value;
    } chain_ctrl_t;

endpackage

// ===== hdl/ordered_array_insert_remove_unit.sv =====
// Ordered list unit: a row of oai_cell shift cells plus a small controller.
// Append, prepend, insert, remove, clear: result beat the cycle after the command; one command
// per cycle while the output is free. Print: the command enters the print state, which emits the
// elements one per cycle while the chain rotates and m_ready does not stall; no command until done.
// Synchronous active-low reset clears count, state and output valid; cells are not reset.
// Depends on oai_pkg and oai_cell.
module ordered_array_insert_remove_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [oai_pkg::CMD_W-1:0]        s_command,
    input  logic [oai_pkg::INDEX_W-1:0]      s_index,
    input  logic signed [oai_pkg::ELEM_W-1:0] s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [oai_pkg::ELEM_W-1:0] m_element,
    output logic [oai_pkg::POSITION_W-1:0]   m_position,
    output logic                             m_last,
    output logic [oai_pkg::CNT_W-1:0]        m_count,
    output logic [oai_pkg::STATUS_W-1:0]     m_status
);

    oai_pkg::state_t      state_reg, state_next;
    oai_pkg::count_t      count_reg, count_next;
    oai_pkg::count_t      prt_reg, prt_next;
    logic                 m_valid_reg, m_valid_next;
    oai_pkg::elem_t       m_element_reg, m_element_next;
    oai_pkg::position_t   m_position_reg, m_position_next;
    logic                 m_last_reg, m_last_next;
    oai_pkg::count_t      m_count_reg, m_count_next;
    oai_pkg::status_t     m_status_reg, m_status_next;

    oai_pkg::chain_ctrl_t ctrl;
    oai_pkg::elem_t       cell_data [oai_pkg::CAPACITY];

    logic                 out_free;
    logic                 full;
    logic                 emit;
    oai_pkg::count_t      count_m1;
    oai_pkg::cpos_t       ins_pos;
    oai_pkg::cpos_t       rem_pos;

    // Cell chain
    for (genvar i = 0; i < oai_pkg::CAPACITY; i++) begin : g_cell
        oai_pkg::elem_t lower_w;
        oai_pkg::elem_t upper_w;
        if (i == 0) begin : g_first
            assign lower_w = s_value;
        end else begin : g_mid_lo
            assign lower_w = cell_data[i-1];
        end
        if (i == oai_pkg::CAPACITY - 1) begin : g_last
            assign upper_w = cell_data[0];
        end else begin : g_mid_hi
            assign upper_w = cell_data[i+1];
        end
        oai_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (oai_pkg::cpos_t'(i)),
            .ctrl       (ctrl),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    // Status flags and position clamping
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == oai_pkg::count_t'(oai_pkg::CAPACITY));
    assign count_m1 = count_reg - oai_pkg::count_t'(1);
    assign emit     = (int'(prt_reg) < oai_pkg::MAX_RESULTS);

    always_comb begin
        ins_pos = '0;
        if (oai_pkg::cmd_t'(s_command) == oai_pkg::CMD_APPEND) begin
            ins_pos = oai_pkg::cpos_t'(count_reg);
        end else if (oai_pkg::cmd_t'(s_command) == oai_pkg::CMD_INSERT) begin
            if (oai_pkg::cmp_t'(s_index) > oai_pkg::cmp_t'(count_reg)) begin
                ins_pos = oai_pkg::cpos_t'(count_reg);
            end else begin
                ins_pos = oai_pkg::cpos_t'(s_index);
            end
        end
    end

    always_comb begin
        if (oai_pkg::cmp_t'(s_index) >= oai_pkg::cmp_t'(count_reg)) begin
            rem_pos = oai_pkg::cpos_t'(count_m1);
        end else begin
            rem_pos = oai_pkg::cpos_t'(s_index);
        end
    end

    // Controller: next state, chain operation and result beat
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        prt_next        = prt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_element_next  = m_element_reg;
        m_position_next = m_position_reg;
        m_last_next     = m_last_reg;
        m_count_next    = m_count_reg;
        m_status_next   = m_status_reg;
        ctrl.op         = oai_pkg::OP_HOLD;
        ctrl.pos        = '0;
        ctrl.value      = s_value;
        s_ready         = 1'b0;

        unique case (state_reg)
            oai_pkg::S_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    // default single-beat result
                    m_valid_next    = 1'b1;
                    m_element_next  = '0;
                    m_position_next = '0;
                    m_last_next     = 1'b1;
                    m_status_next   = oai_pkg::ST_OK;
                    m_count_next    = count_reg;
                    unique case (oai_pkg::cmd_t'(s_command)) inside
                        oai_pkg::CMD_APPEND, oai_pkg::CMD_PREPEND,
                        oai_pkg::CMD_INSERT: begin
                            if (full) begin
                                m_status_next = oai_pkg::ST_FULL;
                            end else begin
                                ctrl.op      = oai_pkg::OP_INSERT;
                                ctrl.pos     = ins_pos;
                                count_next   = count_reg + oai_pkg::count_t'(1);
                                m_count_next = count_reg + oai_pkg::count_t'(1);
                            end
                        end
                        oai_pkg::CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                m_status_next = oai_pkg::ST_EMPTY_REMOVE;
                            end else begin
                                ctrl.op      = oai_pkg::OP_REMOVE;
                                ctrl.pos     = rem_pos;
                                count_next   = count_m1;
                                m_count_next = count_m1;
                            end
                        end
                        oai_pkg::CMD_CLEAR: begin
                            count_next   = '0;
                            m_count_next = '0;
                        end
                        oai_pkg::CMD_PRINT: begin
                            if (count_reg == '0) begin
                                m_status_next = oai_pkg::ST_EMPTY_PRINT;
                            end else begin
                                m_valid_next = 1'b0;
                                prt_next     = '0;
                                state_next   = oai_pkg::S_PRINT;
                            end
                        end
                        default: begin
                            m_status_next = oai_pkg::ST_OK;
                        end
                    endcase
                end
            end
            oai_pkg::S_PRINT: begin
                // one rotation step per cycle; stalls only when a beat cannot go out
                if (!emit || out_free) begin
                    ctrl.op  = oai_pkg::OP_ROTATE;
                    ctrl.pos = oai_pkg::cpos_t'(count_m1);
                    if (emit) begin
                        m_valid_next    = 1'b1;
                        m_element_next  = cell_data[0];
                        m_position_next = oai_pkg::position_t'(prt_reg);
                        m_last_next     = (prt_reg == count_m1)
                                       || (int'(prt_reg) == oai_pkg::MAX_RESULTS - 1);
                        m_count_next    = count_reg;
                        m_status_next   = oai_pkg::ST_OK;
                    end
                    if (prt_reg == count_m1) begin
                        state_next = oai_pkg::S_IDLE;
                    end else begin
                        prt_next = prt_reg + oai_pkg::count_t'(1);
                    end
                end
            end
            default: begin
                state_next = oai_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= oai_pkg::S_IDLE;
            count_reg   <= '0;
            prt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            prt_reg     <= prt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_element_reg  <= m_element_next;
        m_position_reg <= m_position_next;
        m_last_reg     <= m_last_next;
        m_count_reg    <= m_count_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_element  = m_element_reg;
    assign m_position = m_position_reg;
    assign m_last     = m_last_reg;
    assign m_count    = m_count_reg;
    assign m_status   = m_status_reg;

endmodule

// ===== hdl/oai_cell.sv =====
// One storage cell of the shift chain: holds one element and takes data from its lower
// or upper neighbor, the new value or the head element. Depends on oai_pkg.
module oai_cell (
    input  logic                aclk,
    input  oai_pkg::cpos_t      cell_idx,
    input  oai_pkg::chain_ctrl_t ctrl,
    input  oai_pkg::elem_t      lower_data,
    input  oai_pkg::elem_t      upper_data,
    input  oai_pkg::elem_t      head_data,
    output oai_pkg::elem_t      data
);

    oai_pkg::elem_t data_reg;
    oai_pkg::elem_t data_next;

    // Per-cell choice from the broadcast operation and position
    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            oai_pkg::OP_INSERT: begin
                if (cell_idx > ctrl.pos) begin
                    data_next = lower_data;
                end else if (cell_idx == ctrl.pos) begin
                    data_next = ctrl.value;
                end
            end
            oai_pkg::OP_REMOVE: begin
                if (cell_idx >= ctrl.pos) begin
                    data_next = upper_data;
                end
            end
            // rotate toward the head; the tail cell takes the old head
            oai_pkg::OP_ROTATE: begin
                if (cell_idx == ctrl.pos) begin
                    data_next = head_data;
                end else begin
                    data_next = upper_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/oai_checker.sv =====
// Port-level checks of the ordered list unit, bound to the top level.
// Depends on oai_pkg and ordered_array_insert_remove_unit_macros.svh.
`include "ordered_array_insert_remove_unit_macros.svh"

module oai_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_ready,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic signed [oai_pkg::ELEM_W-1:0] m_element,
    input  logic [oai_pkg::POSITION_W-1:0]   m_position,
    input  logic                             m_last,
    input  logic [oai_pkg::CNT_W-1:0]        m_count,
    input  logic [oai_pkg::STATUS_W-1:0]     m_status
);

    // stalled result beat holds
    `OAI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_element) && $stable(m_count) && $stable(m_last))

    // empty print is a single zero beat
    `OAI_ASSERT_SAME(a_empty_print, aclk, aresetn, m_valid && (m_status == oai_pkg::ST_EMPTY_PRINT), m_last && (m_count == '0) && (m_element == '0) && (m_position == '0))

    // only a print stream has beats that are not last
    `OAI_ASSERT_SAME(a_stream_ok, aclk, aresetn, m_valid && !m_last, m_status == oai_pkg::ST_OK)

    // input is held off while a print stream is running
    `OAI_ASSERT_SAME(a_print_blocks, aclk, aresetn, m_valid && !m_last, !s_ready)

endmodule

bind ordered_array_insert_remove_unit oai_checker u_oai_checker (.*);
